// ===== hdl/cq_pkg.sv =====
// shared types, constants and helpers for the circular queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cq_pkg;

    localparam int DEPTH  = 8;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int IN_W   = ((OP_W + WORD_W + 7) / 8) * 8;

    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_DISPLAY = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic    wr_en;
        logic    rd_head;
        logic    rd_cursor;
        logic    disp_init;
        logic    head_adv;
        logic    out_load;
        t_status out_status;
        logic    out_use_mem;
        logic    out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic one_left;
    } t_dp_stat;

    function automatic t_ptr next_slot(input t_ptr i);
        next_slot = (i == t_ptr'(DEPTH - 1)) ? '0 : t_ptr'(i + t_ptr'(1));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/circular_queue.sv =====
// circular queue top level: insert, empty and full reports appear in the cycle after the request;
// delete passes through the memory read register and then the output register; display gives its
// first entry the same way and then one entry per cycle while the sink is ready
// a new request is taken once the previous one has issued its last result
// the single registered memory read port sits between a delete or display request and its data
// reset (synchronous, active low) empties the queue and drops the output; storage is not cleared
`timescale 1ns / 1ps
`default_nettype none

module circular_queue
    import cq_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [IN_W-1:0] s_axis_tdata,   // opcode[1:0], value[33:2], zero pad
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [WORD_W-1:0]    m_axis_tdata,   // data_out[31:0]
    output logic [ST_W-1:0]      m_axis_tuser,   // status[1:0]
    output logic                 m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_opcode  opcode;
    t_word    value;
    t_status  out_status;
    t_word    out_data;

    assign opcode = t_opcode'(s_axis_tdata[OP_W-1:0]);
    assign value  = t_word'(s_axis_tdata[OP_W+WORD_W-1:OP_W]);

    cq_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_opcode  (opcode),
        .i_stat    (stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    cq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (value),
        .i_m_ready  (m_axis_tready),
        .o_stat     (stat),
        .o_m_valid  (m_axis_tvalid),
        .o_m_status (out_status),
        .o_m_data   (out_data),
        .o_m_last   (m_axis_tlast)
    );

    assign m_axis_tuser = ST_W'(out_status);
    assign m_axis_tdata = WORD_W'(out_data);

endmodule

`default_nettype wire

// ===== hdl/cq_datapath.sv =====
// storage ring, head and tail pointers, display cursor and output register
// depends on cq_pkg
`timescale 1ns / 1ps
`default_nettype none

module cq_datapath
    import cq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_word    i_value,
    input  wire logic     i_m_ready,
    output t_dp_stat      o_stat,
    output logic          o_m_valid,
    output t_status       o_m_status,
    output t_word         o_m_data,
    output logic          o_m_last
);

    t_word   mem [DEPTH];
    t_word   r_rd_data;
    t_ptr    r_head, n_head;
    t_ptr    r_tail, n_tail;
    logic    r_empty, n_empty;
    t_ptr    r_cursor, n_cursor;
    t_cnt    r_remain, n_remain;
    logic    r_out_valid;
    t_status r_out_status;
    t_word   r_out_data;
    logic    r_out_last;

    logic    full;
    logic    out_free;
    logic    rd_en;
    t_ptr    rd_addr;
    t_cnt    fill_count;

    assign full     = !r_empty && (r_head == r_tail);
    assign out_free = !r_out_valid || i_m_ready;
    assign rd_en    = i_cmd.rd_head || i_cmd.rd_cursor;
    assign rd_addr  = i_cmd.rd_head ? r_head : r_cursor;

    always_comb begin
        if (full) begin
            fill_count = t_cnt'(DEPTH);
        end else if (r_tail > r_head) begin
            fill_count = t_cnt'(r_tail) - t_cnt'(r_head);
        end else begin
            fill_count = t_cnt'(DEPTH) - t_cnt'(r_head) + t_cnt'(r_tail);
        end
    end

    // ring storage, single write and single registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_tail] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_cursor = r_cursor;
        n_remain = r_remain;
        if (i_cmd.wr_en) begin
            n_tail  = next_slot(r_tail);
            n_empty = 1'b0;
        end
        if (i_cmd.head_adv) begin
            n_head = next_slot(r_head);
            if (next_slot(r_head) == r_tail) begin
                n_empty = 1'b1;
            end
        end
        if (i_cmd.disp_init) begin
            n_cursor = next_slot(r_head);
            n_remain = fill_count;
        end else if (i_cmd.rd_cursor) begin
            n_cursor = next_slot(r_cursor);
            n_remain = r_remain - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_cursor    <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_empty  <= n_empty;
            r_cursor <= n_cursor;
            r_remain <= n_remain;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_data   <= i_cmd.out_use_mem ? r_rd_data : '0;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_stat.empty    = r_empty;
    assign o_stat.full     = full;
    assign o_stat.out_free = out_free;
    assign o_stat.one_left = (r_remain == t_cnt'(1));

    assign o_m_valid  = r_out_valid;
    assign o_m_status = r_out_status;
    assign o_m_data   = r_out_data;
    assign o_m_last   = r_out_last;

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> !full)
        else $error("write into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.head_adv |-> !r_empty)
        else $error("head advanced on an empty queue");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("pending result overwritten");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_cursor |-> (r_remain > t_cnt'(1)))
        else $error("display read past the tail");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == r_tail))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ===== hdl/cq_controller.sv =====
// request decode and sequencing of delete and display reads
// depends on cq_pkg
`timescale 1ns / 1ps
`default_nettype none

module cq_controller
    import cq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_valid,
    input  wire t_opcode  i_opcode,
    input  wire t_dp_stat i_stat,
    output logic          o_s_ready,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_disp, n_disp;

    always_comb begin
        n_state   = r_state;
        n_disp    = r_disp;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        o_cmd.out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_s_ready = i_stat.out_free;
                if (i_s_valid && i_stat.out_free) begin
                    case (i_opcode)
                        OP_INSERT: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.wr_en = 1'b1;
                            end
                        end
                        OP_DELETE, OP_DISPLAY: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_head   = 1'b1;
                                o_cmd.disp_init = (i_opcode == OP_DISPLAY);
                                n_disp          = (i_opcode == OP_DISPLAY);
                                n_state         = S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_use_mem = 1'b1;
                    if (!r_disp) begin
                        o_cmd.out_last = 1'b1;
                        o_cmd.head_adv = 1'b1;
                        n_state        = S_IDLE;
                    end else if (i_stat.one_left) begin
                        o_cmd.out_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.rd_cursor = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_disp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_disp  <= n_disp;
        end
    end

endmodule

`default_nettype wire
